// ----- src/assert_macros.svh -----
// assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tsb assertion failed");
`define TSB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsb assertion failed");
`else
`define TSB_ASSERT(lbl, clk, rst, prop)
`define TSB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/tsb_pkg.sv -----
// shared types and constants of the text screen buffer
`timescale 1ns / 1ps
package tsb_pkg;

  localparam int SCREEN_ROWS_DEF = 25;
  localparam int SCREEN_COLS_DEF = 80;
  localparam int ROW_MAX_W       = 6;
  localparam int COL_MAX_W       = 8;
  localparam int MV_W            = 10;
  localparam int FIFO_DEPTH_DEF  = 2;
  localparam logic [7:0] BLANK   = 8'h20;

  localparam logic [3:0] OP_PRINT     = 4'd0;
  localparam logic [3:0] OP_SETFMT    = 4'd1;
  localparam logic [3:0] OP_SETCUR    = 4'd2;
  localparam logic [3:0] OP_MOVECUR   = 4'd3;
  localparam logic [3:0] OP_ERASE_EOL = 4'd4;
  localparam logic [3:0] OP_ERASE_SOL = 4'd5;
  localparam logic [3:0] OP_ERASE_EOS = 4'd6;
  localparam logic [3:0] OP_ERASE_SOS = 4'd7;
  localparam logic [3:0] OP_ERASE_LN  = 4'd8;
  localparam logic [3:0] OP_ERASE_SCR = 4'd9;
  localparam logic [3:0] OP_NEWLINE   = 4'd10;
  localparam logic [3:0] OP_BACKSP    = 4'd11;
  localparam logic [3:0] OP_SINGLE    = 4'd12;
  localparam logic [3:0] OP_DOUBLE    = 4'd13;
  localparam logic [3:0] OP_READ      = 4'd14;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [7:0]        char_code;
    logic [7:0]        format_mask;
    logic              enable_bit;
    logic [4:0]        target_row;
    logic [6:0]        target_col;
    logic signed [7:0] delta_row;
    logic signed [7:0] delta_col;
  } cmd_in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_format;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic [7:0] active_format;
    logic       double_mode_out;
  } rsp_t;

  // classified command as queued between front and back
  typedef struct packed {
    logic [3:0]           opcode;
    logic [7:0]           char_code;
    logic [7:0]           format_mask;
    logic                 enable_bit;
    logic [ROW_MAX_W-1:0] row;
    logic [COL_MAX_W-1:0] col;
    logic signed [7:0]    delta_row;
    logic signed [7:0]    delta_col;
    logic                 rd_ok;
  } cmd_t;

endpackage

// ----- src/text_screen_buffer_writer_top.sv -----
// top level of the character-cell text screen buffer
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Terminal screen store of SCREEN_ROWS x SCREEN_COLS cells, each a character
// and a format byte, with cursor, current format and double-line flag.
// cmd channel (cmd_valid/cmd_ready/cmd): one terminal command per item.
// rsp channel (rsp_valid/rsp_ready/rsp): exactly one result item per command,
// in order, with the read cell (read command only) and the state afterwards.
// A two-entry queue takes commands while the back end works or waits.
// Cursor, format and mode commands finish in the state that takes them from the
// queue; read and backspace pass through a cell read state; an erase fetches a
// format and then writes its cells one by one; each scrolled line copies the store
// up a row through the single-port-write cell memory and blanks the new bottom row.
// The cell memory is the limit: one cell written per cycle.
// After reset the back end blanks every cell of the store before it runs the first
// command; the queue still fills.
// While rsp_ready is low the result is held and no new command starts.
module text_screen_buffer_writer_top #(
  parameter int SCREEN_ROWS = tsb_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = tsb_pkg::SCREEN_COLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  tsb_pkg::cmd_in_t cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output tsb_pkg::rsp_t    rsp
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  tsb_pkg::cmd_t q_in;
  tsb_pkg::cmd_t q_head;

  tsb_front #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_front (
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  tsb_fifo #(
    .DEPTH (tsb_pkg::FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tsb_back #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // back end never pops an empty queue
  `TSB_ASSERT(a_pop_nonempty, clk, rst, !q_pop || !q_empty)
  // one command in flight: a taken result is never followed at once by another
  `TSB_ASSERT_NEXT(a_one_in_flight, clk, rst, rsp_valid && rsp_ready, !rsp_valid)
  // no pop while a result still waits
  `TSB_ASSERT(a_no_pop_when_held, clk, rst, !(q_pop && rsp_valid))

endmodule

// ----- src/tsb_front.sv -----
// command front end: accepts items, clamps targets and queues them
`timescale 1ns / 1ps
module tsb_front #(
  parameter int SCREEN_ROWS = tsb_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = tsb_pkg::SCREEN_COLS_DEF
) (
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  tsb_pkg::cmd_in_t cmd,
  input  logic             q_full,
  output logic             q_push,
  output tsb_pkg::cmd_t    q_data
);

  localparam logic [tsb_pkg::ROW_MAX_W-1:0] LAST_ROW = tsb_pkg::ROW_MAX_W'(SCREEN_ROWS - 1);
  localparam logic [tsb_pkg::COL_MAX_W-1:0] LAST_COL = tsb_pkg::COL_MAX_W'(SCREEN_COLS - 1);

  logic [tsb_pkg::ROW_MAX_W-1:0] trow;
  logic [tsb_pkg::COL_MAX_W-1:0] tcol;

  assign cmd_ready = !q_full;
  assign q_push    = cmd_valid && !q_full;

  always_comb begin
    trow = tsb_pkg::ROW_MAX_W'(cmd.target_row);
    tcol = tsb_pkg::COL_MAX_W'(cmd.target_col);
    q_data.opcode      = cmd.opcode;
    q_data.char_code   = cmd.char_code;
    q_data.format_mask = cmd.format_mask;
    q_data.enable_bit  = cmd.enable_bit;
    q_data.delta_row   = cmd.delta_row;
    q_data.delta_col   = cmd.delta_col;
    q_data.row         = (trow > LAST_ROW) ? LAST_ROW : trow;
    q_data.col         = (tcol > LAST_COL) ? LAST_COL : tcol;
    q_data.rd_ok       = (trow <= LAST_ROW) && (tcol <= LAST_COL);
  end

endmodule

// ----- src/tsb_fifo.sv -----
// short command queue between front and back
`timescale 1ns / 1ps
module tsb_fifo #(
  parameter int DEPTH = tsb_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tsb_pkg::cmd_t push_data,
  input  logic          pop,
  output tsb_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  tsb_pkg::cmd_t   entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/tsb_back.sv -----
// command back end: cursor state, cell store sequencer and result register
`timescale 1ns / 1ps
module tsb_back #(
  parameter int SCREEN_ROWS = tsb_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = tsb_pkg::SCREEN_COLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tsb_pkg::cmd_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tsb_pkg::rsp_t rsp
);

  localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CW     = $clog2(CELLS + 1);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int MV_W   = tsb_pkg::MV_W;

  localparam logic [CW-1:0]    CELL_LAST = CW'(CELLS - 1);
  localparam logic [CW-1:0]    ROW_SPAN  = CW'(SCREEN_COLS);
  localparam logic [CW-1:0]    COPY_LAST = CW'((SCREEN_ROWS - 1) * SCREEN_COLS - 1);
  localparam logic [CW-1:0]    BOT_BASE  = CW'((SCREEN_ROWS - 1) * SCREEN_COLS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [ROW_W-1:0] PEN_ROW   = ROW_W'(SCREEN_ROWS - 2);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(SCREEN_COLS - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FMT    = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_BS     = 3'd6;
  localparam logic [2:0] S_RD     = 3'd7;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [15:0] wdata;
  logic we;

  logic [2:0] state, state_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [7:0] cur_fmt, cur_fmt_next;
  logic dbl, dbl_next;
  logic [3:0] op_r, op_r_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] split, split_next;
  logic [7:0] fmt_a, fmt_a_next;
  logic [7:0] fmt_b, fmt_b_next;
  logic [1:0] scroll_cnt, scroll_cnt_next;
  logic out_valid, out_valid_next;
  tsb_pkg::rsp_t out_data, out_data_next;

  logic [CW-1:0] base;
  logic [CW-1:0] cur_pos;
  logic [CW-1:0] rd_pos;
  logic signed [MV_W-1:0] mv_row;
  logic signed [MV_W-1:0] mv_col;
  logic [ROW_W+1:0] nl_row;
  logic fin;
  logic [7:0] fin_char;
  logic [7:0] fin_fmt;

  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  always_comb begin
    base    = CW'(cur_row) * ROW_SPAN;
    cur_pos = base + CW'(cur_col);
    rd_pos  = CW'(q_head.row[ROW_W-1:0]) * ROW_SPAN + CW'(q_head.col[COL_W-1:0]);
    mv_row  = signed'(MV_W'(cur_row)) + MV_W'(q_head.delta_row);
    mv_col  = signed'(MV_W'(cur_col)) + MV_W'(q_head.delta_col);
    nl_row  = (ROW_W + 2)'(cur_row) + (dbl ? (ROW_W + 2)'(2) : (ROW_W + 2)'(1));
  end

  always_comb begin
    state_next      = state;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    cur_fmt_next    = cur_fmt;
    dbl_next        = dbl;
    op_r_next       = op_r;
    ptr_next        = ptr;
    hi_next         = hi;
    split_next      = split;
    fmt_a_next      = fmt_a;
    fmt_b_next      = fmt_b;
    scroll_cnt_next = scroll_cnt;
    q_pop           = 1'b0;
    raddr           = '0;
    we              = 1'b0;
    waddr           = ptr[ADDR_W-1:0];
    wdata           = {8'h00, tsb_pkg::BLANK};
    fin             = 1'b0;
    fin_char        = 8'h00;
    fin_fmt         = 8'h00;

    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (ptr == CELL_LAST) begin
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty && !out_valid) begin
          q_pop     = 1'b1;
          op_r_next = q_head.opcode;
          unique case (q_head.opcode)
            tsb_pkg::OP_PRINT: begin
              we    = 1'b1;
              waddr = cur_pos[ADDR_W-1:0];
              wdata = {cur_fmt, q_head.char_code};
              if (cur_col == LAST_COL) begin
                cur_col_next = '0;
                if (cur_row == LAST_ROW || (dbl && cur_row >= PEN_ROW)) begin
                  scroll_cnt_next = dbl ? 2'd2 : 2'd1;
                  ptr_next        = '0;
                  state_next      = S_SCROLL;
                end else begin
                  cur_row_next = cur_row + (dbl ? ROW_W'(2) : ROW_W'(1));
                  fin          = 1'b1;
                end
              end else begin
                cur_col_next = cur_col + 1'b1;
                fin          = 1'b1;
              end
            end
            tsb_pkg::OP_SETFMT: begin
              cur_fmt_next = q_head.enable_bit ? (cur_fmt | q_head.format_mask)
                                               : (cur_fmt & ~q_head.format_mask);
              fin = 1'b1;
            end
            tsb_pkg::OP_SETCUR: begin
              cur_row_next = q_head.row[ROW_W-1:0];
              cur_col_next = q_head.col[COL_W-1:0];
              fin = 1'b1;
            end
            tsb_pkg::OP_MOVECUR: begin
              if (mv_row < 0) begin
                cur_row_next = '0;
              end else if (mv_row > signed'(MV_W'(SCREEN_ROWS - 1))) begin
                cur_row_next = LAST_ROW;
              end else begin
                cur_row_next = ROW_W'(mv_row);
              end
              if (mv_col < 0) begin
                cur_col_next = '0;
              end else if (mv_col > signed'(MV_W'(SCREEN_COLS - 1))) begin
                cur_col_next = LAST_COL;
              end else begin
                cur_col_next = COL_W'(mv_col);
              end
              fin = 1'b1;
            end
            tsb_pkg::OP_ERASE_EOL, tsb_pkg::OP_ERASE_SOL, tsb_pkg::OP_ERASE_EOS,
            tsb_pkg::OP_ERASE_SOS, tsb_pkg::OP_ERASE_LN, tsb_pkg::OP_ERASE_SCR: begin
              // fetch the format of column 0 on the cursor row first
              raddr      = base[ADDR_W-1:0];
              state_next = S_FMT;
            end
            tsb_pkg::OP_NEWLINE: begin
              if (nl_row > (ROW_W + 2)'(SCREEN_ROWS - 1)) begin
                scroll_cnt_next = 2'(nl_row - (ROW_W + 2)'(SCREEN_ROWS - 1));
                cur_row_next    = LAST_ROW;
                ptr_next        = '0;
                state_next      = S_SCROLL;
              end else begin
                cur_row_next = ROW_W'(nl_row);
                fin          = 1'b1;
              end
            end
            tsb_pkg::OP_BACKSP: begin
              if (cur_col != '0) begin
                cur_col_next = cur_col - 1'b1;
                ptr_next     = cur_pos - 1'b1;
                raddr        = ADDR_W'(cur_pos - 1'b1);
                state_next   = S_BS;
              end else begin
                fin = 1'b1;
              end
            end
            tsb_pkg::OP_SINGLE: begin
              dbl_next = 1'b0;
              fin      = 1'b1;
            end
            tsb_pkg::OP_DOUBLE: begin
              dbl_next = 1'b1;
              fin      = 1'b1;
            end
            tsb_pkg::OP_READ: begin
              if (q_head.rd_ok) begin
                raddr      = rd_pos[ADDR_W-1:0];
                state_next = S_RD;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_FMT: begin
        split_next = '0;
        state_next = S_FILL;
        unique case (op_r)
          tsb_pkg::OP_ERASE_EOL: begin
            ptr_next   = cur_pos;
            hi_next    = base + ROW_SPAN - 1'b1;
            fmt_b_next = cur_fmt;
          end
          tsb_pkg::OP_ERASE_SOL: begin
            ptr_next   = base;
            hi_next    = cur_pos;
            fmt_b_next = rdata[15:8];
          end
          tsb_pkg::OP_ERASE_EOS: begin
            // line rest: cur fmt; rows below: col 0 fmt, or cur fmt at col 0
            ptr_next   = cur_pos;
            hi_next    = CELL_LAST;
            split_next = base + ROW_SPAN;
            fmt_a_next = cur_fmt;
            fmt_b_next = (cur_col == '0) ? cur_fmt : rdata[15:8];
          end
          tsb_pkg::OP_ERASE_SOS: begin
            ptr_next   = '0;
            hi_next    = cur_pos;
            fmt_b_next = rdata[15:8];
          end
          tsb_pkg::OP_ERASE_LN: begin
            ptr_next   = base;
            hi_next    = base + ROW_SPAN - 1'b1;
            fmt_b_next = rdata[15:8];
          end
          default: begin
            ptr_next   = '0;
            hi_next    = CELL_LAST;
            fmt_b_next = cur_fmt;
          end
        endcase
      end
      S_FILL: begin
        we    = 1'b1;
        wdata = {(ptr < split) ? fmt_a : fmt_b, tsb_pkg::BLANK};
        if (ptr == hi) begin
          if (scroll_cnt > 2'd1) begin
            scroll_cnt_next = scroll_cnt - 1'b1;
            ptr_next        = '0;
            state_next      = S_SCROLL;
          end else begin
            scroll_cnt_next = '0;
            state_next      = S_IDLE;
            fin             = 1'b1;
          end
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_SCROLL: begin
        // read one row ahead, write the word read last cycle
        raddr = ADDR_W'(ptr + ROW_SPAN);
        if (ptr != '0) begin
          we    = 1'b1;
          waddr = ADDR_W'(ptr - 1'b1);
          wdata = rdata;
        end
        if (ptr == COPY_LAST) begin
          state_next = S_DRAIN;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_DRAIN: begin
        we         = 1'b1;
        wdata      = rdata;
        ptr_next   = BOT_BASE;
        hi_next    = CELL_LAST;
        split_next = '0;
        fmt_b_next = cur_fmt;
        state_next = S_FILL;
      end
      S_BS: begin
        we         = 1'b1;
        wdata      = {rdata[15:8], tsb_pkg::BLANK};
        state_next = S_IDLE;
        fin        = 1'b1;
      end
      S_RD: begin
        fin_char   = rdata[7:0];
        fin_fmt    = rdata[15:8];
        state_next = S_IDLE;
        fin        = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = out_valid;
    out_data_next  = out_data;
    if (fin) begin
      out_valid_next                = 1'b1;
      out_data_next.cell_char       = fin_char;
      out_data_next.cell_format     = fin_fmt;
      out_data_next.cursor_row_out  = 5'(cur_row_next);
      out_data_next.cursor_col_out  = 7'(cur_col_next);
      out_data_next.active_format   = cur_fmt_next;
      out_data_next.double_mode_out = dbl_next;
    end else if (out_valid && rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    hi       <= hi_next;
    split    <= split_next;
    fmt_a    <= fmt_a_next;
    fmt_b    <= fmt_b_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ptr        <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      cur_fmt    <= '0;
      dbl        <= 1'b0;
      scroll_cnt <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      cur_fmt    <= cur_fmt_next;
      dbl        <= dbl_next;
      scroll_cnt <= scroll_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule
